### sv/stq_pkg.sv
package stq_pkg;

  localparam int MAX_RESULTS = 16;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  localparam logic [1:0] KIND_INSERTED = 2'd0;
  localparam logic [1:0] KIND_REPLACED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_EXPIRED  = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] delay_seconds;
    logic [15:0] timer_id;
  } stq_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_number;
    logic [15:0] out_seconds;
    logic        last;
  } stq_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EXPIRE
  } stq_state_t;

endpackage

### sv/stq_front.sv
module stq_front import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  stq_req_t req,
  output logic     q_valid,
  output stq_req_t q_item,
  input  logic     q_pop
);

  // two-entry request queue
  stq_req_t slot [2];
  logic     rd_ptr;
  logic     wr_ptr;
  logic [1:0] fill;
  logic     push;

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### sv/stq_back.sv
module stq_back import stq_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  stq_req_t q_item,
  output logic     q_pop,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output stq_rsp_t rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] expiry [TABLE_DEPTH];
  logic [15:0]          dly    [TABLE_DEPTH];
  logic [15:0]          ids    [TABLE_DEPTH];
  logic [CW-1:0]        count;
  logic [NW-1:0]        n_out;

  stq_state_t state, state_next;
  stq_req_t             cur;
  logic [TIME_BITS-1:0] cur_exp;
  logic [1:0]           cur_kind;

  logic [TABLE_DEPTH-1:0] match, lt;
  logic                   found;
  logic [IW-1:0]          found_idx;
  logic                   full;
  logic [TIME_BITS:0]     exp_sum;
  logic [TIME_BITS-1:0]   exp_sat;
  logic                   out_ok, due, exp_last;

  logic          shift_en;
  logic [IW-1:0] shift_idx;
  logic          ins_en, take_set, tick_en, emit;
  stq_rsp_t      emit_rsp;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CW'(i) < count) && (ids[i] == q_item.timer_id);
      lt[i]    = (CW'(i) < count) && (expiry[i] < cur_exp);
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  assign full    = (count == CW'(TABLE_DEPTH));
  assign exp_sum = {1'b0, now} + (TIME_BITS + 1)'(q_item.delay_seconds);
  assign exp_sat = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
  assign out_ok  = !rsp_valid || !rsp_stall;
  assign due     = (count != '0) && (expiry[0] <= now) && (n_out < NW'(MAX_RESULTS));
  assign exp_last = (n_out == NW'(MAX_RESULTS - 1)) || (count == CW'(1)) || (expiry[1] > now);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    shift_en   = 1'b0;
    shift_idx  = '0;
    ins_en     = 1'b0;
    take_set   = 1'b0;
    tick_en    = 1'b0;
    emit       = 1'b0;
    emit_rsp   = '{kind: KIND_EXPIRED, out_number: ids[0], out_seconds: dly[0],
                   last: exp_last};
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.mode == MODE_SET) begin
            if (found || !full) begin
              q_pop      = 1'b1;
              take_set   = 1'b1;
              shift_en   = found;
              shift_idx  = found_idx;
              state_next = ST_INSERT;
            end else if (out_ok) begin
              q_pop    = 1'b1;
              emit     = 1'b1;
              emit_rsp = '{kind: KIND_REJECTED, out_number: q_item.timer_id,
                           out_seconds: q_item.delay_seconds, last: 1'b1};
            end
          end else begin
            q_pop      = 1'b1;
            tick_en    = 1'b1;
            state_next = ST_EXPIRE;
          end
        end
      end
      ST_INSERT: begin
        if (out_ok) begin
          ins_en     = 1'b1;
          emit       = 1'b1;
          emit_rsp   = '{kind: cur_kind, out_number: cur.timer_id,
                         out_seconds: cur.delay_seconds, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_EXPIRE: begin
        if (!due) begin
          state_next = ST_IDLE;
        end else if (out_ok) begin
          emit     = 1'b1;
          shift_en = 1'b1;
          if (exp_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_set) begin
      cur      <= q_item;
      cur_exp  <= exp_sat;
      cur_kind <= found ? KIND_REPLACED : KIND_INSERTED;
    end
    if (emit) begin
      rsp <= emit_rsp;
    end
    if (shift_en) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (IW'(i) >= shift_idx) begin
          expiry[i] <= expiry[i+1];
          dly[i]    <= dly[i+1];
          ids[i]    <= ids[i+1];
        end
      end
    end
    if (ins_en) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!lt[i]) begin
          if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
            expiry[i] <= cur_exp;
            dly[i]    <= cur.delay_seconds;
            ids[i]    <= cur.timer_id;
          end else begin
            expiry[i] <= expiry[(i == 0) ? 0 : i-1];
            dly[i]    <= dly[(i == 0) ? 0 : i-1];
            ids[i]    <= ids[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
    if (rst) begin
      now       <= '0;
      count     <= '0;
      n_out     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (tick_en) begin
        n_out <= '0;
        if (now != '1) begin
          now <= now + 1'b1;
        end
      end else if (emit && state == ST_EXPIRE) begin
        n_out <= n_out + 1'b1;
      end
      if (shift_en) begin
        count <= count - 1'b1;
      end else if (ins_en) begin
        count <= count + 1'b1;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> expiry[0] <= expiry[1]) else $error("table head out of order");
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> now >= $past(now)) else $error("time went backward");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !emit) else $error("held result overwritten");

endmodule

### sv/sorted_timer_queue.sv
// Sorted timer queue. A set request (mode 1) passes through the table back
// end's insert state unless it is rejected for a full table; a tick steps
// through the expire state and gives one result per expired timer, up to
// 16 per tick. The pace is set by the single table update port and the one
// result register; a two-entry request queue sits ahead of the table so
// requests are taken while results wait.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  stq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output stq_rsp_t rsp
);

  logic     q_valid;
  stq_req_t q_item;
  logic     q_pop;

  stq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  stq_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
